/* rtl/u8e_pkg.sv */
// Shared types and constants for the UTF-8 encoder with a per-string byte budget.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package u8e_pkg;

  localparam int unsigned CpWidth     = 21;
  localparam int unsigned CountWidth  = 16;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned InDataWidth = 40;
  localparam int unsigned InUserWidth = 2;
  localparam int unsigned OutDataWidth = 24;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [WordWidth-1:0] Mask2 = 32'h0000_C080;
  localparam logic [WordWidth-1:0] Mask3 = 32'h00E0_8080;
  localparam logic [WordWidth-1:0] Mask4 = 32'hF080_8080;

  localparam logic [CountWidth-1:0] CountMax = '1;

  // One accepted character waiting to be sent out byte by byte.
  typedef struct packed {
    logic [WordWidth-1:0]  word;
    logic [1:0]            len_m1;
    logic [CountWidth-1:0] base;
  } char_t;

  // Saturating add of a small increment to the running count.
  function automatic logic [CountWidth-1:0] sat_add(logic [CountWidth-1:0] a,
                                                    logic [2:0] b);
    logic [CountWidth:0] s;
    s = {1'b0, a} + {{(CountWidth-2){1'b0}}, b};
    sat_add = s[CountWidth] ? CountMax : s[CountWidth-1:0];
  endfunction

endpackage

/* rtl/u8e_front.sv */
// Front end: accepts code points, keeps the per-string count and stop flag,
// encodes each character and pushes the ones that fit into the queue. Uses u8e_pkg.
module u8e_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [u8e_pkg::CpWidth-1:0]   code_point_i,
  input  logic                          first_of_string_i,
  input  logic                          has_limit_i,
  input  logic [u8e_pkg::CountWidth-1:0] byte_limit_i,
  output logic                          push_o,
  output u8e_pkg::char_t                push_data_o
);
  import u8e_pkg::*;

  logic [CountWidth-1:0] byte_count_q, byte_count_d;
  logic                  stopped_q, stopped_d;
  logic [CountWidth-1:0] count_eff;
  logic                  stop_eff;
  logic [1:0]            len_m1;
  logic [2:0]            len;
  logic [WordWidth-1:0]  word;
  logic [CountWidth:0]   sum;
  logic                  over;
  logic                  accept;
  logic                  emit;

  assign accept    = in_valid_i && in_ready_i;
  assign count_eff = first_of_string_i ? '0 : byte_count_q;
  assign stop_eff  = first_of_string_i ? 1'b0 : stopped_q;

  always_comb begin
    if (code_point_i[20:16] != '0) begin
      len_m1 = 2'd3;
      word   = Mask4 | {5'd0, code_point_i[20:18], 2'd0, code_point_i[17:12],
                        2'd0, code_point_i[11:6], 2'd0, code_point_i[5:0]};
    end else if (code_point_i[15:11] != '0) begin
      len_m1 = 2'd2;
      word   = Mask3 | {12'd0, code_point_i[15:12], 2'd0, code_point_i[11:6],
                        2'd0, code_point_i[5:0]};
    end else if (code_point_i[10:7] != '0) begin
      len_m1 = 2'd1;
      word   = Mask2 | {19'd0, code_point_i[10:6], 2'd0, code_point_i[5:0]};
    end else begin
      len_m1 = 2'd0;
      word   = {25'd0, code_point_i[6:0]};
    end
  end

  assign len  = {1'b0, len_m1} + 3'd1;
  assign sum  = {1'b0, count_eff} + {{(CountWidth-2){1'b0}}, len};
  assign over = has_limit_i && (sum > {1'b0, byte_limit_i});
  assign emit = accept && !stop_eff && (code_point_i != '0) && !over;

  always_comb begin
    byte_count_d = byte_count_q;
    stopped_d    = stopped_q;
    if (accept) begin
      if (emit) begin
        byte_count_d = sat_add(count_eff, len);
        stopped_d    = 1'b0;
      end else begin
        byte_count_d = count_eff;
        stopped_d    = 1'b1;
      end
    end
  end

  assign push_o             = emit;
  assign push_data_o.word   = word;
  assign push_data_o.len_m1 = len_m1;
  assign push_data_o.base   = count_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      stopped_q    <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      stopped_q    <= stopped_d;
    end
  end

endmodule

/* rtl/u8e_fifo.sv */
// Short queue of encoded characters between the front and back ends.
// Register storage with combinational head read; uses u8e_pkg for the entry type.
module u8e_fifo #(
  parameter int unsigned Depth = u8e_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  u8e_pkg::char_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output u8e_pkg::char_t head_o
);
  import u8e_pkg::*;

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  char_t                entries_q [Depth];
  logic [PtrWidth-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]  count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/u8e_back.sv */
// Back end: takes encoded characters from the queue and sends them one byte
// per request through a registered output stage. Uses u8e_pkg.
module u8e_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  u8e_pkg::char_t                 head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [u8e_pkg::ByteWidth-1:0]  out_byte_o,
  output logic                           last_of_char_o,
  output logic [u8e_pkg::CountWidth-1:0] bytes_emitted_o
);
  import u8e_pkg::*;

  logic [1:0]            idx_q, idx_d;
  logic                  valid_q, valid_d;
  logic [ByteWidth-1:0]  byte_q, byte_d;
  logic                  last_q, last_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  load;
  logic                  is_last;
  logic [1:0]            shift;

  assign load    = !valid_q || out_ready_i;
  assign is_last = (idx_q == head_i.len_m1);
  assign shift   = head_i.len_m1 - idx_q;
  assign pop_o   = load && !empty_i && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    cnt_d   = cnt_q;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        byte_d = head_i.word[{shift, 3'b000} +: ByteWidth];
        last_d = is_last;
        cnt_d  = sat_add(head_i.base, {1'b0, idx_q} + 3'd1);
        idx_d  = is_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    cnt_q  <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign last_of_char_o  = last_q;
  assign bytes_emitted_o = cnt_q;

endmodule

/* rtl/utf8_encoder_with_byte_budget_top.sv */
// UTF-8 encoder with a per-string byte budget: top level.
// The slave side takes one code point per request with its budget controls.
// The master side gives one encoded byte per request with tlast on the final
// byte of each character and the running byte count of the string.
// A front end accepts a request in every cycle while the queue has room,
// encodes it and decides whether it fits the budget; dropped characters and
// string terminators produce no output. A back end sends queued characters
// at one byte per cycle while the receiver is ready; a character has one to
// four bytes, and the output byte rate sets the throughput.
// The first byte of a character passes the queue and then the output register.
// When the receiver stalls, the output register holds its byte, the queue
// fills and then tready drops; nothing is lost. Reset clears the count, the
// stop flag, the queue and the output valid.
// Depends on u8e_pkg, u8e_front, u8e_fifo and u8e_back.
module utf8_encoder_with_byte_budget_top #(
  parameter int unsigned QueueDepth = u8e_pkg::QueueDepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // Fields from bit 0: code_point[20:0], byte_limit[36:21], zero pad.
  input  logic [u8e_pkg::InDataWidth-1:0]  s_axis_tdata_i,
  // Fields from bit 0: first_of_string, has_limit.
  input  logic [u8e_pkg::InUserWidth-1:0]  s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // Fields from bit 0: out_byte[7:0], bytes_emitted[23:8].
  output logic [u8e_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);
  import u8e_pkg::*;

  char_t                 push_data;
  char_t                 head;
  logic                  push;
  logic                  full;
  logic                  empty;
  logic                  pop;
  logic [ByteWidth-1:0]  out_byte;
  logic [CountWidth-1:0] bytes_emitted;

  assign s_axis_tready_o = !full;

  u8e_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid_i),
    .in_ready_i        (s_axis_tready_o),
    .code_point_i      (s_axis_tdata_i[CpWidth-1:0]),
    .first_of_string_i (s_axis_tuser_i[0]),
    .has_limit_i       (s_axis_tuser_i[1]),
    .byte_limit_i      (s_axis_tdata_i[CpWidth +: CountWidth]),
    .push_o            (push),
    .push_data_o       (push_data)
  );

  u8e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  u8e_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_byte_o      (out_byte),
    .last_of_char_o  (m_axis_tlast_o),
    .bytes_emitted_o (bytes_emitted)
  );

  assign m_axis_tdata_o = {bytes_emitted, out_byte};

endmodule

/* tb/utf8_encoder_with_byte_budget_top_test.sv */
// Self-checking testbench for utf8_encoder_with_byte_budget_top: code points with budget
// controls go in, each output byte is checked against a built-in UTF-8 encoder model.
// Depends on u8e_pkg and the RTL of the encoder; needs nothing else.
module utf8_encoder_with_byte_budget_top_test;
  import u8e_pkg::*;

  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned RandomReqs = 389;
  localparam int unsigned MaxPrints  = 20;

  typedef struct packed {
    logic [20:0] cp;
    logic        first;
    logic        lim_en;
    logic [15:0] limit;
  } char_req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic [15:0] count;
  } enc_byte_t;

  typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_valid = 1'b0;
  logic                    s_ready;
  char_req_t               cur_req = '0;
  logic [InDataWidth-1:0]  s_tdata;
  logic [InUserWidth-1:0]  s_tuser;
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic [OutDataWidth-1:0] m_tdata;
  logic                    m_tlast;

  assign s_tdata = {{(InDataWidth-37){1'b0}}, cur_req.limit, cur_req.cp};
  assign s_tuser = {cur_req.lim_en, cur_req.first};

  utf8_encoder_with_byte_budget_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  char_req_t pending_reqs[$];
  enc_byte_t expected_bytes[$];

  logic [15:0] str_count = '0;
  logic        str_stopped = 1'b0;
  int unsigned n_chars = 0;
  int unsigned n_dropped = 0;
  int unsigned n_ignored = 0;
  int unsigned n_checked = 0;
  int unsigned err_cnt = 0;
  bit          sat_seen = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < MaxPrints) begin
      $display("ERROR at output byte %0d: %s got 0x%0h, expected 0x%0h",
               n_checked, what, got, want);
    end
    err_cnt++;
  endtask

  // Encodes one accepted request into the bytes the encoder must send.
  task automatic predict_utf8(input char_req_t req);
    logic [7:0]  enc[4];
    int          len;
    enc_byte_t   eb;
    if (req.first) begin
      str_count = '0;
      str_stopped = 1'b0;
    end
    if (str_stopped) begin
      n_ignored++;
      return;
    end
    if (req.cp == '0) begin
      str_stopped = 1'b1;
      return;
    end
    if (req.cp[20:7] == '0) begin
      len = 1;
      enc[0] = {1'b0, req.cp[6:0]};
    end else if (req.cp[20:11] == '0) begin
      len = 2;
      enc[0] = {3'b110, req.cp[10:6]};
      enc[1] = {2'b10, req.cp[5:0]};
    end else if (req.cp[20:16] == '0) begin
      len = 3;
      enc[0] = {4'b1110, req.cp[15:12]};
      enc[1] = {2'b10, req.cp[11:6]};
      enc[2] = {2'b10, req.cp[5:0]};
    end else begin
      len = 4;
      enc[0] = {5'b11110, req.cp[20:18]};
      enc[1] = {2'b10, req.cp[17:12]};
      enc[2] = {2'b10, req.cp[11:6]};
      enc[3] = {2'b10, req.cp[5:0]};
    end
    if (req.lim_en && ({1'b0, str_count} + 17'(len) > {1'b0, req.limit})) begin
      str_stopped = 1'b1;
      n_dropped++;
      return;
    end
    for (int k = 0; k < len; k++) begin
      if (str_count != 16'hFFFF) begin
        str_count = str_count + 16'd1;
      end else begin
        sat_seen = 1'b1;
      end
      eb.out_byte = enc[k];
      eb.last = (k == len - 1);
      eb.count = str_count;
      expected_bytes.push_back(eb);
    end
    n_chars++;
  endtask

  // Request driver: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      cur_req <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_valid || s_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        cur_req <= pending_reqs.pop_front();
        s_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_valid && s_ready) begin
      predict_utf8(cur_req);
    end
  end

  // Receiver: randomly chosen stall modes; two long hold-offs fill the queue.
  int unsigned rx_cyc = 0;
  rx_mode_e    rx_mode = RX_FREE;
  int unsigned hold_left = 0;
  int unsigned hold_idx = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      rx_cyc <= 0;
      rx_mode <= RX_FREE;
      hold_left <= 0;
      hold_idx <= 0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (rx_cyc % 128 == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_ready <= 1'b0;
      end else if (hold_idx < 2 && n_checked >= ((hold_idx == 0) ? 100 : 300)) begin
        hold_left <= 80;
        hold_idx <= hold_idx + 1;
        m_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE: begin
            m_ready <= 1'b1;
          end
          RX_HALF: begin
            m_ready <= 1'($urandom_range(0, 1));
          end
          RX_SPARSE: begin
            m_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            m_ready <= ~m_ready;
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    enc_byte_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", 32'(m_tdata), 0);
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata[7:0] !== want.out_byte) begin
          report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(want.out_byte));
        end
        if (m_tlast !== want.last) begin
          report_mismatch("last_of_char", 32'(m_tlast), 32'(want.last));
        end
        if (m_tdata[23:8] !== want.count) begin
          report_mismatch("bytes_emitted", 32'(m_tdata[23:8]), 32'(want.count));
        end
      end
      n_checked++;
    end
  end

  int unsigned idle_cnt = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cnt <= 0;
      end else if (idle_cnt + 1 >= IdleLimit) begin
        $display("utf8_encoder_with_byte_budget_top: mismatch");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  task automatic add_req(input logic [20:0] cp, input logic first, input logic lim_en,
                         input logic [15:0] limit);
    char_req_t r;
    r.cp = cp;
    r.first = first;
    r.lim_en = lim_en;
    r.limit = limit;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [20:0] rand_char();
    case ($urandom_range(0, 3))
      0: rand_char = 21'($urandom_range(1, 21'h7F));
      1: rand_char = 21'($urandom_range(21'h80, 21'h7FF));
      2: rand_char = 21'($urandom_range(21'h800, 21'hFFFF));
      default: rand_char = 21'($urandom_range(21'h10000, 21'h1FFFFF));
    endcase
  endfunction

  task automatic add_random_string();
    logic        lim_en;
    logic [15:0] limit;
    int          nchars;
    lim_en = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 9))
      0: limit = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      1, 2: limit = 16'($urandom_range(0, 16'hFFFF));
      default: limit = 16'($urandom_range(0, 24));
    endcase
    nchars = $urandom_range(1, 8);
    add_req(rand_char(), ($urandom_range(0, 9) != 0), lim_en, limit);
    for (int k = 1; k < nchars; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        add_req(21'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                16'($urandom));
      end else begin
        add_req(rand_char(), 1'b0, lim_en, limit);
      end
    end
    if ($urandom_range(0, 1) != 0) begin
      add_req('0, 1'b0, lim_en, limit);
    end
  endtask

  initial begin
    int unsigned target;

    // Count continues from reset without a first mark; every length boundary.
    add_req(21'h41, 1'b0, 1'b0, 16'h0000);
    add_req(21'h7F, 1'b0, 1'b0, 16'h0000);
    add_req(21'h80, 1'b0, 1'b0, 16'h0000);
    add_req(21'h7FF, 1'b0, 1'b0, 16'h0000);
    add_req(21'h800, 1'b0, 1'b0, 16'h0000);
    add_req(21'hFFFF, 1'b0, 1'b0, 16'h0000);
    add_req(21'h10000, 1'b0, 1'b0, 16'h0000);
    add_req(21'h1FFFFF, 1'b0, 1'b0, 16'hFFFF);
    add_req(21'h0, 1'b0, 1'b0, 16'h0000);
    add_req(21'h1, 1'b0, 1'b0, 16'h0000);
    // A budget that fits exactly, then a character over it and one after the stop.
    add_req(21'h41, 1'b1, 1'b1, 16'd6);
    add_req(21'h7FF, 1'b0, 1'b1, 16'd6);
    add_req(21'hFFFF, 1'b0, 1'b1, 16'd6);
    add_req(21'h42, 1'b0, 1'b1, 16'd6);
    add_req(21'h43, 1'b0, 1'b1, 16'd6);
    add_req(21'h41, 1'b1, 1'b1, 16'd0);
    add_req(21'h10000, 1'b1, 1'b1, 16'd3);
    add_req(21'h0, 1'b1, 1'b0, 16'h0000);
    add_req(21'h155555, 1'b1, 1'b1, 16'hFFFF);
    add_req(21'h0AAAAA, 1'b0, 1'b1, 16'h8000);
    add_req(21'h0, 1'b0, 1'b1, 16'h7FFF);

    target = pending_reqs.size() + RandomReqs;
    while (pending_reqs.size() < target) begin
      add_random_string();
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i); while (pending_reqs.size() != 0 || s_valid);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Run covered %0d encoded characters, %0d over budget, %0d ignored after a stop,",
             n_chars, n_dropped, n_ignored);
    $display("and %0d output bytes checked; count saturation reached: %0d.",
             n_checked, sat_seen);
    if (err_cnt == 0 && expected_bytes.size() == 0) begin
      $display("utf8_encoder_with_byte_budget_top: match");
    end else begin
      $display("utf8_encoder_with_byte_budget_top: mismatch");
    end
    $finish;
  end

endmodule
